// ===== src/sbq_pkg.sv =====
package sbq_pkg;

    localparam int COEF_WIDTH         = 32;
    localparam int NUM_COEFS          = 5;
    localparam int CFG_IDX_W          = 3;
    localparam int DEF_SAMPLE_WIDTH   = 24;
    localparam int DEF_COEF_FRAC_BITS = 24;

    localparam logic [CFG_IDX_W-1:0] IDX_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_A2 = 3'd4;

    localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 32'sd16777216;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic start;
        logic mac1;
        logic mac2;
        logic mac3;
        logic adv;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC1,
        ST_MAC2,
        ST_MAC3,
        ST_DONE
    } t_seq_state;

endpackage

// ===== src/sbq_if.sv =====
interface sbq_in_if #(
    parameter int SAMPLE_WIDTH = sbq_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sbq_out_if #(
    parameter int SAMPLE_WIDTH = sbq_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
    logic                           clipped;

    modport source (output valid, output left_out, output right_out, output clipped,
                    input ready);
    modport sink (input valid, input left_out, input right_out, input clipped,
                  output ready);
endinterface

// ===== src/stereo_biquad_filter.sv =====
// Stereo direct form I biquad: both channels of a frame run through one shared set of five
// Q8.24 coefficients in two parallel lanes, each with its own delay line, and the rounded and
// saturated samples leave together with a clip flag. A frame passes through three
// multiply-accumulate steps, using one feed-forward and one feedback multiplier per lane, and
// one rounding step; the output delay feedback closes in that last step, so a new frame is
// accepted only once the previous one has finished it. A finished frame waits in the output
// register while the next one is already being computed. The user is to write coefficients
// through the configuration port while the filter is idle; the block does not enforce this.
module stereo_biquad_filter #(
    parameter int SAMPLE_WIDTH   = sbq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = sbq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbq_in_if.sink                         i_in,
    sbq_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbq_pkg::COEF_WIDTH-1:0] i_cfg_data
);

    sbq_pkg::t_coefs                w_coefs;
    sbq_pkg::t_lane_ctl             w_ctl;
    logic                           w_ready;
    logic                           w_out_ok;
    logic signed [SAMPLE_WIDTH-1:0] w_y_left;
    logic signed [SAMPLE_WIDTH-1:0] w_y_right;
    logic                           w_sat_left;
    logic                           w_sat_right;

    assign i_in.ready = w_ready;

    sbq_coef_regs u_coefs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_coefs (w_coefs)
    );

    sbq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_ok   (w_out_ok),
        .o_in_ready (w_ready),
        .o_ctl      (w_ctl)
    );

    sbq_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coefs (w_coefs),
        .i_x     (i_in.left_in),
        .o_y     (w_y_left),
        .o_sat   (w_sat_left)
    );

    sbq_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coefs (w_coefs),
        .i_x     (i_in.right_in),
        .o_y     (w_y_right),
        .o_sat   (w_sat_right)
    );

    sbq_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_ctl.adv),
        .i_left      (w_y_left),
        .i_right     (w_y_right),
        .i_sat_left  (w_sat_left),
        .i_sat_right (w_sat_right),
        .o_ok        (w_out_ok),
        .o_out       (o_out)
    );

endmodule

// ===== src/sbq_coef_regs.sv =====
module sbq_coef_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [sbq_pkg::COEF_WIDTH-1:0] i_data,
    output sbq_pkg::t_coefs                o_coefs
);

    sbq_pkg::t_coefs r_coefs;
    sbq_pkg::t_coefs n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_we) begin
            unique case (i_idx)
                sbq_pkg::IDX_B0: n_coefs.b0 = i_data;
                sbq_pkg::IDX_B1: n_coefs.b1 = i_data;
                sbq_pkg::IDX_B2: n_coefs.b2 = i_data;
                sbq_pkg::IDX_A1: n_coefs.a1 = i_data;
                sbq_pkg::IDX_A2: n_coefs.a2 = i_data;
                default:         n_coefs    = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= sbq_pkg::B0_RESET;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ===== src/sbq_seq.sv =====
module sbq_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ok,
    output logic                o_in_ready,
    output sbq_pkg::t_lane_ctl  o_ctl
);

    sbq_pkg::t_seq_state r_state;
    sbq_pkg::t_seq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            sbq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.start = 1'b1;
                    n_state     = sbq_pkg::ST_MAC1;
                end
            end
            sbq_pkg::ST_MAC1: begin
                o_ctl.mac1 = 1'b1;
                n_state    = sbq_pkg::ST_MAC2;
            end
            sbq_pkg::ST_MAC2: begin
                o_ctl.mac2 = 1'b1;
                n_state    = sbq_pkg::ST_MAC3;
            end
            sbq_pkg::ST_MAC3: begin
                o_ctl.mac3 = 1'b1;
                n_state    = sbq_pkg::ST_DONE;
            end
            sbq_pkg::ST_DONE: begin
                if (i_out_ok) begin
                    o_ctl.adv  = 1'b1;
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_ctl.start = 1'b1;
                        n_state     = sbq_pkg::ST_MAC1;
                    end else begin
                        n_state = sbq_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sbq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sbq_lane.sv =====
module sbq_lane #(
    parameter int SAMPLE_WIDTH   = sbq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = sbq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sbq_pkg::t_lane_ctl             i_ctl,
    input  sbq_pkg::t_coefs                i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_sat
);

    localparam int PW = sbq_pkg::COEF_WIDTH + SAMPLE_WIDTH;
    localparam int AW = PW + 3;
    localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SMAX = {{(AW-SAMPLE_WIDTH+1){1'b0}},
                                             {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = ~SMAX;

    logic signed [SAMPLE_WIDTH-1:0]        r_x;
    logic signed [SAMPLE_WIDTH-1:0]        r_x1;
    logic signed [SAMPLE_WIDTH-1:0]        r_x2;
    logic signed [SAMPLE_WIDTH-1:0]        r_y1;
    logic signed [SAMPLE_WIDTH-1:0]        r_y2;
    logic signed [PW-1:0]                  r_pa;
    logic signed [PW-1:0]                  r_pb;
    logic signed [AW-1:0]                  r_acc;
    logic signed [AW-1:0]                  n_acc;

    logic signed [sbq_pkg::COEF_WIDTH-1:0] w_ca;
    logic signed [sbq_pkg::COEF_WIDTH-1:0] w_cb;
    logic signed [SAMPLE_WIDTH-1:0]        w_xa;
    logic signed [SAMPLE_WIDTH-1:0]        w_yb;
    logic signed [PW-1:0]                  w_pa;
    logic signed [PW-1:0]                  w_pb;
    logic signed [AW-1:0]                  w_rnd;
    logic signed [AW-1:0]                  w_shf;

    // The feed-forward multiplier walks b0, b1, b2 while the feedback one walks a2, a1.
    always_comb begin
        w_ca = i_coefs.b0;
        w_xa = i_x;
        w_cb = i_coefs.a2;
        w_yb = i_ctl.adv ? r_y1 : r_y2;
        priority if (i_ctl.mac1) begin
            w_ca = i_coefs.b1;
            w_xa = r_x1;
            w_cb = i_coefs.a1;
            w_yb = r_y1;
        end else if (i_ctl.mac2) begin
            w_ca = i_coefs.b2;
            w_xa = r_x2;
            w_cb = '0;
            w_yb = r_y1;
        end
    end

    assign w_pa = w_ca * w_xa;
    assign w_pb = w_cb * w_yb;

    always_comb begin
        n_acc = (i_ctl.mac1 ? {AW{1'b0}} : r_acc)
              + {{(AW-PW){r_pa[PW-1]}}, r_pa}
              - {{(AW-PW){r_pb[PW-1]}}, r_pb};
    end

    assign w_rnd = r_acc + HALF;
    assign w_shf = w_rnd >>> COEF_FRAC_BITS;

    always_comb begin
        o_sat = 1'b0;
        o_y   = w_shf[SAMPLE_WIDTH-1:0];
        priority if (w_shf > SMAX) begin
            o_sat = 1'b1;
            o_y   = SMAX[SAMPLE_WIDTH-1:0];
        end else if (w_shf < SMIN) begin
            o_sat = 1'b1;
            o_y   = SMIN[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= w_pa;
        r_pb <= w_pb;
        if (i_ctl.start) begin
            r_x <= i_x;
        end
        if (i_ctl.mac1 || i_ctl.mac2 || i_ctl.mac3) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_ctl.adv) begin
            r_x2 <= r_x1;
            r_x1 <= r_x;
            r_y2 <= r_y1;
            r_y1 <= o_y;
        end
    end

endmodule

// ===== src/sbq_merge.sv =====
module sbq_merge #(
    parameter int SAMPLE_WIDTH = sbq_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right,
    input  logic                           i_sat_left,
    input  logic                           i_sat_right,
    output logic                           o_ok,
    sbq_out_if.source                      o_out
);

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_right;
    logic                           r_clipped;

    assign o_ok = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left    <= i_left;
            r_right   <= i_right;
            r_clipped <= i_sat_left | i_sat_right;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.left_out  = r_left;
    assign o_out.right_out = r_right;
    assign o_out.clipped   = r_clipped;

endmodule

// ===== src/sbq_chk.sv =====
module sbq_chk #(
    parameter int SAMPLE_WIDTH = sbq_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] i_left_out,
    input logic signed [SAMPLE_WIDTH-1:0] i_right_out,
    input logic                           i_clipped
);

    localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_left_out) && $stable(i_right_out) && $stable(i_clipped))
        else $error("output word changed while stalled");

    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready)
        else $error("input word accepted before the previous frame finished");

    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc, 5))
        else $error("output word appeared without a matching input word");

    a_clip_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |->
            (i_left_out == SMAX) || (i_left_out == SMIN) ||
            (i_right_out == SMAX) || (i_right_out == SMIN))
        else $error("clip flag set without a saturated sample");

endmodule

bind stereo_biquad_filter sbq_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sbq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left_out  (o_out.left_out),
    .i_right_out (o_out.right_out),
    .i_clipped   (o_out.clipped)
);
